// ===== rtl/core/tpp_pkg.sv =====
// Shared widths, register indexes and types for the triangle point predicate block.
package tpp_pkg;

  // Coordinate width of vertices and query points.
  localparam int COORD_BITS = 16;

  // A coordinate difference needs one more bit.
  localparam int DIFF_W = COORD_BITS + 1;
  // A product of two differences, or a sum of two squares.
  localparam int MUL_W = 2 * DIFF_W;
  // Twice a signed area: the difference of two products.
  localparam int ORI_W = MUL_W + 1;
  // Sum of three area magnitudes.
  localparam int ABS_W = ORI_W + 1;
  // Sum of squares, kept signed for the wide multiply.
  localparam int SQ_W = MUL_W;

  // The wide multiply is cut into four partial products at this bit.
  localparam int SPL_L = (ORI_W + 1) / 2;
  localparam int SQ_H  = SQ_W - SPL_L;
  localparam int ORI_H = ORI_W - SPL_L;

  // One incircle term and the full determinant.
  localparam int TERM_W = SQ_W + ORI_W;
  localparam int DET_W  = TERM_W + 2;

  // Pipeline depth of the query path.
  localparam int STAGES = 6;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AX = 3'd0,
    REG_AY = 3'd1,
    REG_BX = 3'd2,
    REG_BY = 3'd3,
    REG_CX = 3'd4,
    REG_CY = 3'd5
  } cfg_reg_t;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [MUL_W-1:0]      mul_t;
  typedef logic signed [ORI_W-1:0]      ori_t;

endpackage

// ===== rtl/core/triangle_point_predicates.sv =====
// Top level: exact incircle, point-in-triangle and vertex-match tests for one triangle.
// Each accepted input beat passes through the six register stages to its result beat.
// Throughput is one query per cycle while out_stall is low; the register stages move
// independently, so bubbles close up and a beat is taken whenever stage 1 is empty or moving.
// The triangle-area path is registered in wp1_r/wp2_r, then whole_r, then wabs_r/wneg_r/wnz_r.
// Reset (synchronous, rst_n low) clears all vertex registers to 0 and empties the pipeline.
module triangle_point_predicates (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [tpp_pkg::COORD_BITS-1:0] in_point_x,
  input  logic signed [tpp_pkg::COORD_BITS-1:0] in_point_y,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_in_circumcircle,
  output logic                                 out_in_triangle,
  output logic                                 out_is_vertex,
  input  logic                                 cfg_we,
  input  logic [tpp_pkg::CFG_IDX_W-1:0]        cfg_idx,
  input  logic [tpp_pkg::COORD_BITS-1:0]       cfg_wdata
);

  // Vertex registers.
  tpp_pkg::coord_t ax_r, ay_r, bx_r, by_r, cx_r, cy_r;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r <= '0;
      ay_r <= '0;
      bx_r <= '0;
      by_r <= '0;
      cx_r <= '0;
      cy_r <= '0;
    end else if (cfg_we) begin
      unique case (tpp_pkg::cfg_reg_t'(cfg_idx))
        tpp_pkg::REG_AX: ax_r <= $signed(cfg_wdata);
        tpp_pkg::REG_AY: ay_r <= $signed(cfg_wdata);
        tpp_pkg::REG_BX: bx_r <= $signed(cfg_wdata);
        tpp_pkg::REG_BY: by_r <= $signed(cfg_wdata);
        tpp_pkg::REG_CX: cx_r <= $signed(cfg_wdata);
        tpp_pkg::REG_CY: cy_r <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Whole-triangle area, derived from the vertices over three register steps.
  tpp_pkg::diff_t  wbx, wby, wcx, wcy;
  tpp_pkg::mul_t   wp1_r, wp2_r;
  tpp_pkg::ori_t   whole_r;
  logic [tpp_pkg::ORI_W-1:0] wabs_r;
  logic            wneg_r, wnz_r;

  assign wbx = tpp_pkg::DIFF_W'(bx_r) - tpp_pkg::DIFF_W'(ax_r);
  assign wby = tpp_pkg::DIFF_W'(by_r) - tpp_pkg::DIFF_W'(ay_r);
  assign wcx = tpp_pkg::DIFF_W'(cx_r) - tpp_pkg::DIFF_W'(ax_r);
  assign wcy = tpp_pkg::DIFF_W'(cy_r) - tpp_pkg::DIFF_W'(ay_r);

  always_ff @(posedge clk) begin
    wp1_r   <= wbx * wcy;
    wp2_r   <= wby * wcx;
    whole_r <= tpp_pkg::ORI_W'(wp1_r) - tpp_pkg::ORI_W'(wp2_r);
    wabs_r  <= whole_r[tpp_pkg::ORI_W-1] ? $unsigned(-whole_r) : $unsigned(whole_r);
    wneg_r  <= whole_r[tpp_pkg::ORI_W-1];
    wnz_r   <= (whole_r != '0);
  end

  // Stage handshake: a stage loads when it is empty or its successor moves.
  logic [tpp_pkg::STAGES:1]   v_r;
  logic [tpp_pkg::STAGES+1:1] rdy;

  always_comb begin
    rdy[tpp_pkg::STAGES+1] = !out_stall;
    for (int k = tpp_pkg::STAGES; k >= 1; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_stall  = !rdy[1];
  assign out_valid = v_r[tpp_pkg::STAGES];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[1]) begin
        v_r[1] <= in_valid;
      end
      for (int k = 2; k <= tpp_pkg::STAGES; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Stage 1: vertex minus point, and the vertex match.
  tpp_pkg::diff_t d_r [6];
  logic           vert1_r;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      d_r[0]  <= tpp_pkg::DIFF_W'(ax_r) - tpp_pkg::DIFF_W'(in_point_x);
      d_r[1]  <= tpp_pkg::DIFF_W'(ay_r) - tpp_pkg::DIFF_W'(in_point_y);
      d_r[2]  <= tpp_pkg::DIFF_W'(bx_r) - tpp_pkg::DIFF_W'(in_point_x);
      d_r[3]  <= tpp_pkg::DIFF_W'(by_r) - tpp_pkg::DIFF_W'(in_point_y);
      d_r[4]  <= tpp_pkg::DIFF_W'(cx_r) - tpp_pkg::DIFF_W'(in_point_x);
      d_r[5]  <= tpp_pkg::DIFF_W'(cy_r) - tpp_pkg::DIFF_W'(in_point_y);
      vert1_r <= (in_point_x == ax_r && in_point_y == ay_r) ||
                 (in_point_x == bx_r && in_point_y == by_r) ||
                 (in_point_x == cx_r && in_point_y == cy_r);
    end
  end

  // Stage 2: cross products and squares of the differences.
  tpp_pkg::mul_t m_r [6];
  tpp_pkg::mul_t q_r [6];
  logic          vert2_r;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      m_r[0] <= d_r[0] * d_r[3];
      m_r[1] <= d_r[1] * d_r[2];
      m_r[2] <= d_r[2] * d_r[5];
      m_r[3] <= d_r[3] * d_r[4];
      m_r[4] <= d_r[4] * d_r[1];
      m_r[5] <= d_r[5] * d_r[0];
      for (int i = 0; i < 6; i++) begin
        q_r[i] <= d_r[i] * d_r[i];
      end
      vert2_r <= vert1_r;
    end
  end

  // Stage 3: sub-areas PAB, PBC, PCA and the squared distances to A, B, C.
  tpp_pkg::ori_t s_r  [3];
  tpp_pkg::mul_t sq_r [3];
  logic          vert3_r;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      for (int i = 0; i < 3; i++) begin
        s_r[i]  <= tpp_pkg::ORI_W'(m_r[2*i]) - tpp_pkg::ORI_W'(m_r[2*i+1]);
        sq_r[i] <= q_r[2*i] + q_r[2*i+1];
      end
      vert3_r <= vert2_r;
    end
  end

  // Each incircle term pairs a squared distance with the opposite sub-area.
  tpp_pkg::ori_t cr [3];
  assign cr[0] = s_r[1];
  assign cr[1] = s_r[2];
  assign cr[2] = s_r[0];

  // Stage 4: four partial products per term, and the sub-area magnitudes.
  logic        [2*tpp_pkg::SPL_L-1:0]                pll_r [3];
  logic signed [tpp_pkg::SPL_L+tpp_pkg::ORI_H:0]     plh_r [3];
  logic signed [tpp_pkg::SQ_H+tpp_pkg::SPL_L:0]      phl_r [3];
  logic signed [tpp_pkg::SQ_H+tpp_pkg::ORI_H-1:0]    phh_r [3];
  logic        [tpp_pkg::ORI_W-1:0]                  abs_r [3];
  logic                                              vert4_r;

  logic        [tpp_pkg::SPL_L-1:0] al [3];
  logic        [tpp_pkg::SPL_L-1:0] bl [3];
  logic signed [tpp_pkg::SQ_H-1:0]  ah [3];
  logic signed [tpp_pkg::ORI_H-1:0] bh [3];

  always_comb begin
    for (int t = 0; t < 3; t++) begin
      al[t] = sq_r[t][tpp_pkg::SPL_L-1:0];
      ah[t] = $signed(sq_r[t][tpp_pkg::SQ_W-1:tpp_pkg::SPL_L]);
      bl[t] = cr[t][tpp_pkg::SPL_L-1:0];
      bh[t] = $signed(cr[t][tpp_pkg::ORI_W-1:tpp_pkg::SPL_L]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      for (int t = 0; t < 3; t++) begin
        pll_r[t] <= al[t] * bl[t];
        plh_r[t] <= $signed({1'b0, al[t]}) * bh[t];
        phl_r[t] <= ah[t] * $signed({1'b0, bl[t]});
        phh_r[t] <= ah[t] * bh[t];
        abs_r[t] <= s_r[t][tpp_pkg::ORI_W-1] ? $unsigned(-s_r[t]) : $unsigned(s_r[t]);
      end
      vert4_r <= vert3_r;
    end
  end

  // Stage 5: assemble the three terms; compare the area sum with the whole area.
  logic signed [tpp_pkg::TERM_W-1:0] term_r [3];
  logic                              tri5_r;
  logic                              vert5_r;
  logic        [tpp_pkg::ABS_W-1:0]  abs_sum;

  assign abs_sum = tpp_pkg::ABS_W'(abs_r[0]) + tpp_pkg::ABS_W'(abs_r[1]) +
                   tpp_pkg::ABS_W'(abs_r[2]);

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      for (int t = 0; t < 3; t++) begin
        term_r[t] <= (tpp_pkg::TERM_W'(phh_r[t]) <<< (2 * tpp_pkg::SPL_L)) +
                     ((tpp_pkg::TERM_W'(plh_r[t]) + tpp_pkg::TERM_W'(phl_r[t]))
                       <<< tpp_pkg::SPL_L) +
                     tpp_pkg::TERM_W'($signed({1'b0, pll_r[t]}));
      end
      tri5_r  <= (abs_sum == tpp_pkg::ABS_W'(wabs_r));
      vert5_r <= vert4_r;
    end
  end

  // Stage 6: determinant sign against the triangle orientation.
  logic signed [tpp_pkg::DET_W-1:0] det;
  logic                             circ6_r, tri6_r, vert6_r;

  assign det = tpp_pkg::DET_W'(term_r[0]) + tpp_pkg::DET_W'(term_r[1]) +
               tpp_pkg::DET_W'(term_r[2]);

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      circ6_r <= wnz_r && ((det == '0) || (det[tpp_pkg::DET_W-1] == wneg_r));
      tri6_r  <= tri5_r;
      vert6_r <= vert5_r;
    end
  end

  assign out_in_circumcircle = circ6_r;
  assign out_in_triangle     = tri6_r;
  assign out_is_vertex       = vert6_r;

endmodule

// ===== rtl/core/tpp_checker.sv =====
// Port-level checks for the triangle point predicate block, bound to the top level.
module tpp_checker (
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_in_circumcircle,
  input logic out_in_triangle,
  input logic out_is_vertex
);

  // A stalled result beat stays and keeps its flags.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid &&
      $stable({out_in_circumcircle, out_in_triangle, out_is_vertex}))
    else $error("stalled result beat changed");

  // A point on a vertex always lies on the triangle.
  a_vertex_in_tri: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_vertex |-> out_in_triangle)
    else $error("vertex match without triangle match");

  // With the output side free, the pipeline always takes a new beat.
  a_no_stall_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output side is free");

  // The input side stalls only when a result is waiting at the output.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

endmodule

bind triangle_point_predicates tpp_checker u_tpp_checker (.*);
